FILE: rtl/ilt_pkg.sv
// Package: shared types, constants and codes for the indexed list table engine.
`timescale 1ns / 1ps
package ilt_pkg;

   localparam int DEPTH = 64;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // request kinds
   localparam logic [2:0] KIND_PUSH       = 3'd0;
   localparam logic [2:0] KIND_POP        = 3'd1;
   localparam logic [2:0] KIND_INSERT     = 3'd2;
   localparam logic [2:0] KIND_REMOVE_AT  = 3'd3;
   localparam logic [2:0] KIND_REMOVE_VAL = 3'd4;
   localparam logic [2:0] KIND_GET        = 3'd5;
   localparam logic [2:0] KIND_FIND       = 3'd6;

   // status codes
   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_EMPTY    = 3'd1;
   localparam logic [2:0] STAT_FULL     = 3'd2;
   localparam logic [2:0] STAT_BAD_IDX  = 3'd3;
   localparam logic [2:0] STAT_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [2:0]         kind;
      logic [5:0]         position;
      logic signed [31:0] operand_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [5:0]         found_position;
      logic [2:0]         status;
      logic [6:0]         entry_count;
   } rsp_type;

   // per-cycle command broadcast to every cell
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_MARK,
      CELL_COMPACT
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [IDX_W-1:0]   position;
      logic signed [31:0] value;
      logic [CNT_W-1:0]   count;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_COMPACT,
      FSM_FIND
   } fsm_state_type;

endpackage

FILE: rtl/ilt_cell.sv
// One list cell: holds one entry and trades it with its neighbors.
`timescale 1ns / 1ps
module ilt_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ilt_pkg::IDX_W-1:0]   cell_index,
   input  ilt_pkg::cell_ctl_type       ctl,
   input  logic signed [31:0]          left_data,
   input  logic                        left_keep,
   input  logic signed [31:0]          right_data,
   input  logic                        right_keep,
   output logic signed [31:0]          data,
   output logic                        keep,
   output logic                        match
);
   import ilt_pkg::*;

   logic signed [31:0] data_ff, data_in;
   logic               keep_ff, keep_in;
   logic               in_use;

   assign in_use = {1'b0, cell_index} < ctl.count;

   // next entry value and compaction mark
   always_comb begin
      data_in = data_ff;
      keep_in = keep_ff;
      case (ctl.op)
         CELL_WRITE: begin
            if (cell_index == ctl.position) data_in = ctl.value;
         end
         CELL_INSERT: begin
            if (cell_index == ctl.position) data_in = ctl.value;
            else if (cell_index > ctl.position) data_in = left_data;
         end
         CELL_REMOVE: begin
            if (cell_index >= ctl.position) data_in = right_data;
         end
         CELL_MARK: begin
            keep_in = in_use && (data_ff != ctl.value);
         end
         CELL_COMPACT: begin
            // pull a kept entry down into a hole; hand ours down if below is a hole
            if (!keep_ff && right_keep) begin
               data_in = right_data;
               keep_in = 1'b1;
            end else if (keep_ff && !left_keep) begin
               keep_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= 1'b0;
      end else begin
         keep_ff <= keep_in;
      end
   end

   assign data  = data_ff;
   assign keep  = keep_ff;
   assign match = in_use && (data_ff == ctl.value);

endmodule

FILE: rtl/indexed_list_table_engine.sv
// Top level: request sequencer over a row of list cells.
// Push, pop, insert, remove at, get: the request register loads on accept, EXEC forms
// the result, then the result register and strobe load. Find adds the FIND state
// (match vector is registered before the first-index encode). Remove value: EXEC
// marks, then COMPACT passes of the cell row run, under DEPTH; requests are taken only
// in idle. Synchronous active-high reset empties the list; results cannot be stalled.
`timescale 1ns / 1ps
module indexed_list_table_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ilt_pkg::req_type req_item,
   output logic             rsp_strobe,
   output ilt_pkg::rsp_type rsp_item
);
   import ilt_pkg::*;

   fsm_state_type      state_ff, state_in;
   req_type            req_ff, req_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   rsp_type            rsp_ff, rsp_in;
   logic               strobe_ff, strobe_in;
   logic [DEPTH-1:0]   found_ff, found_in;

   cell_ctl_type       ctl;
   logic signed [31:0] cell_data [DEPTH];
   logic [DEPTH-1:0]   cell_keep;
   logic [DEPTH-1:0]   cell_match;

   logic [IDX_W-1:0]   read_sel;
   logic signed [31:0] read_data;
   logic               move_pending;
   logic [CNT_W-1:0]   packed_count;
   logic [DEPTH:0]     keep_lo;
   logic [DEPTH:0]     keep_hi;
   logic [IDX_W-1:0]   first_idx;
   logic               first_hit;
   logic               accept;

   assign accept = start && (state_ff == FSM_IDLE);
   assign busy   = (state_ff != FSM_IDLE);

   // cell row
   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [31:0] left_d, right_d;
      logic               left_k, right_k;
      if (gi == 0) begin : g_first
         assign left_d = cell_data[gi];
         assign left_k = 1'b1;
      end else begin : g_mid_l
         assign left_d = cell_data[gi-1];
         assign left_k = cell_keep[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
         assign right_d = cell_data[gi];
         assign right_k = 1'b0;
      end else begin : g_mid_r
         assign right_d = cell_data[gi+1];
         assign right_k = cell_keep[gi+1];
      end
      ilt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(gi)),
         .ctl        (ctl),
         .left_data  (left_d),
         .left_keep  (left_k),
         .right_data (right_d),
         .right_keep (right_k),
         .data       (cell_data[gi]),
         .keep       (cell_keep[gi]),
         .match      (cell_match[gi])
      );
   end

   // one-hot read of the selected cell
   always_comb begin
      read_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (read_sel == IDX_W'(i)) read_data = read_data | cell_data[i];
      end
   end

   // compaction status: any hole below a kept entry, and length once packed
   assign keep_lo = {cell_keep, 1'b1};
   assign keep_hi = {1'b0, cell_keep};
   always_comb begin
      move_pending = 1'b0;
      for (int i = 0; i < DEPTH - 1; i++) begin
         move_pending = move_pending | (!cell_keep[i] && cell_keep[i+1]);
      end
      packed_count = '0;
      for (int i = 0; i <= DEPTH; i++) begin
         if (keep_lo[i] && !keep_hi[i]) packed_count = packed_count | CNT_W'(i);
      end
   end

   // lowest set bit of the registered match vector
   always_comb begin
      first_idx = '0;
      first_hit = 1'b0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (found_ff[i]) begin
            first_idx = IDX_W'(i);
            first_hit = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FSM_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      found_ff <= found_in;
   end

   // sequencer: next state, cell command and result
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      strobe_in    = 1'b0;
      found_in     = found_ff;
      read_sel     = req_ff.position;
      ctl.op       = CELL_HOLD;
      ctl.position = req_ff.position;
      ctl.value    = req_ff.operand_value;
      ctl.count    = count_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               req_in   = req_item;
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            rsp_in.read_value     = '0;
            rsp_in.found_position = '0;
            rsp_in.status         = STAT_OK;
            strobe_in             = 1'b1;
            state_in              = FSM_IDLE;
            case (req_ff.kind)
               KIND_PUSH: begin
                  if (count_ff >= CNT_W'(DEPTH)) begin
                     rsp_in.status = STAT_FULL;
                  end else begin
                     ctl.op       = CELL_WRITE;
                     ctl.position = count_ff[IDX_W-1:0];
                     count_in     = count_ff + 1'b1;
                  end
               end
               KIND_POP: begin
                  read_sel = IDX_W'(count_ff - 1'b1);
                  if (count_ff == '0) begin
                     rsp_in.status = STAT_EMPTY;
                  end else begin
                     rsp_in.read_value = read_data;
                     count_in          = count_ff - 1'b1;
                  end
               end
               KIND_INSERT: begin
                  if ({1'b0, req_ff.position} > count_ff) begin
                     rsp_in.status = STAT_BAD_IDX;
                  end else if (count_ff >= CNT_W'(DEPTH)) begin
                     rsp_in.status = STAT_FULL;
                  end else begin
                     ctl.op   = CELL_INSERT;
                     count_in = count_ff + 1'b1;
                  end
               end
               KIND_REMOVE_AT: begin
                  if ({1'b0, req_ff.position} >= count_ff) begin
                     rsp_in.status = STAT_BAD_IDX;
                  end else begin
                     ctl.op   = CELL_REMOVE;
                     count_in = count_ff - 1'b1;
                  end
               end
               KIND_REMOVE_VAL: begin
                  if (|cell_match) begin
                     ctl.op    = CELL_MARK;
                     strobe_in = 1'b0;
                     state_in  = FSM_COMPACT;
                  end else begin
                     rsp_in.status = STAT_NOTFOUND;
                  end
               end
               KIND_GET: begin
                  if ({1'b0, req_ff.position} >= count_ff) begin
                     rsp_in.status = STAT_BAD_IDX;
                  end else begin
                     rsp_in.read_value = read_data;
                  end
               end
               KIND_FIND: begin
                  found_in  = cell_match;
                  strobe_in = 1'b0;
                  state_in  = FSM_FIND;
               end
               default: begin
               end
            endcase
            rsp_in.entry_count = 7'(count_in);
         end
         FSM_COMPACT: begin
            if (move_pending) begin
               ctl.op = CELL_COMPACT;
            end else begin
               count_in              = packed_count;
               rsp_in.read_value     = '0;
               rsp_in.found_position = '0;
               rsp_in.status         = STAT_OK;
               rsp_in.entry_count    = 7'(packed_count);
               strobe_in             = 1'b1;
               state_in              = FSM_IDLE;
            end
         end
         FSM_FIND: begin
            rsp_in.read_value     = '0;
            rsp_in.found_position = first_hit ? 6'(first_idx) : '0;
            rsp_in.status         = first_hit ? STAT_OK : STAT_NOTFOUND;
            rsp_in.entry_count    = 7'(count_ff);
            strobe_in             = 1'b1;
            state_in              = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

`ifndef ASSERT_OFF
   // an accepted request always occupies the sequencer next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // at most one result per request, so strobes never come back to back
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe on consecutive cycles");

   // a full rejection only happens at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status == STAT_FULL) |-> rsp_item.entry_count == 7'(DEPTH))
      else $error("full status below capacity");

   // count never exceeds capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above capacity");
`endif

endmodule

FILE: tb/sv/indexed_list_table_engine_tb.sv
// Testbench: self-checking stimulus and list predictor for the indexed list table engine.
`timescale 1ns / 1ps
module indexed_list_table_engine_tb;
   import ilt_pkg::*;

   // kind 7 has no name in the package; the engine must answer it without change
   localparam logic [2:0] KIND_UNDEFINED = 3'd7;
   localparam int         DRAIN_CYCLES   = 2 * DEPTH + 16;
   localparam int         DRAIN_LIMIT    = 4000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // predictor copy of the list
   logic signed [31:0] list_mem [DEPTH];
   int                 list_len = 0;

   rsp_type pending_results [$];
   int      fail_count = 0;
   int      sent_count = 0;
   int      checked_count = 0;
   int      status_seen [5] = '{default: 0};
   int      sender_idle_pct = 0;
   bit      grow_bias = 1'b1;

   indexed_list_table_engine dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   always #10 clock = ~clock;

   // run limit
   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

   // predict one result and update the list copy
   function automatic rsp_type apply_list_op(req_type r);
      rsp_type o;
      int      p;
      int      k;
      int      keep;
      bit      hit;
      o = '0;
      p = r.position;
      hit = 1'b0;
      case (r.kind)
         KIND_PUSH: begin
            if (list_len >= DEPTH) begin
               o.status = STAT_FULL;
            end else begin
               list_mem[list_len] = r.operand_value;
               list_len++;
            end
         end
         KIND_POP: begin
            if (list_len == 0) begin
               o.status = STAT_EMPTY;
            end else begin
               list_len--;
               o.read_value = list_mem[list_len];
            end
         end
         KIND_INSERT: begin
            if (p > list_len) begin
               o.status = STAT_BAD_IDX;
            end else if (list_len >= DEPTH) begin
               o.status = STAT_FULL;
            end else begin
               for (k = list_len; k > p; k--) list_mem[k] = list_mem[k-1];
               list_mem[p] = r.operand_value;
               list_len++;
            end
         end
         KIND_REMOVE_AT: begin
            if (p >= list_len) begin
               o.status = STAT_BAD_IDX;
            end else begin
               for (k = p; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
               list_len--;
            end
         end
         KIND_REMOVE_VAL: begin
            keep = 0;
            for (k = 0; k < list_len; k++) begin
               if (list_mem[k] != r.operand_value) begin
                  list_mem[keep] = list_mem[k];
                  keep++;
               end
            end
            if (keep == list_len) o.status = STAT_NOTFOUND;
            list_len = keep;
         end
         KIND_GET: begin
            if (p >= list_len) o.status = STAT_BAD_IDX;
            else o.read_value = list_mem[p];
         end
         KIND_FIND: begin
            o.status = STAT_NOTFOUND;
            for (k = 0; k < list_len && !hit; k++) begin
               if (list_mem[k] == r.operand_value) begin
                  o.found_position = 6'(k);
                  o.status = STAT_OK;
                  hit = 1'b1;
               end
            end
         end
         default: ;
      endcase
      o.entry_count = 7'(list_len);
      return o;
   endfunction

   // result checker: each strobe against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $error("result strobe with no request outstanding");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            if (rsp_item.status < 5) status_seen[rsp_item.status]++;
            if (rsp_item.read_value !== want.read_value) begin
               $error("read_value: expected %0d, got %0d", want.read_value,
                      rsp_item.read_value);
               fail_count++;
            end
            if (rsp_item.found_position !== want.found_position) begin
               $error("found_position: expected %0d, got %0d", want.found_position,
                      rsp_item.found_position);
               fail_count++;
            end
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_item.status);
               fail_count++;
            end
            if (rsp_item.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d", want.entry_count,
                      rsp_item.entry_count);
               fail_count++;
            end
         end
      end
   end

   // hold one request until the engine takes it; start stays high afterward
   task automatic send_request(input req_type r);
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_item <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      pending_results.push_back(apply_list_op(r));
      sent_count++;
   endtask

   task automatic issue(input logic [2:0] kind, input int pos, input logic [31:0] val);
      req_type r;
      r.kind          = kind;
      r.position      = 6'(pos);
      r.operand_value = val;
      send_request(r);
   endtask

   // quiet the request side and let every outstanding result come back
   task automatic wait_drained();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (pending_results.size() > 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // every failure status on an empty list, plus the undefined kind
   task automatic test_empty_list();
      issue(KIND_POP, 0, 0);
      issue(KIND_GET, 0, 0);
      issue(KIND_REMOVE_AT, 0, 0);
      issue(KIND_REMOVE_AT, 63, 0);
      issue(KIND_INSERT, 1, 5);
      issue(KIND_FIND, 0, 5);
      issue(KIND_REMOVE_VAL, 0, 5);
      issue(KIND_UNDEFINED, 63, 32'hFFFF_FFFF);
   endtask

   // prepend to empty, append at count, shifts, multi-match removal
   task automatic test_edit_ops();
      issue(KIND_INSERT, 0, 32'h7FFF_FFFF);
      issue(KIND_INSERT, 1, 32'h8000_0000);
      issue(KIND_INSERT, 0, 32'hFFFF_FFFF);
      issue(KIND_PUSH, 0, 32'h0000_0000);
      issue(KIND_PUSH, 0, 32'hFFFF_FFFF);
      issue(KIND_INSERT, 2, 7);
      issue(KIND_GET, 0, 0);
      issue(KIND_GET, 5, 0);
      issue(KIND_GET, 6, 0);
      issue(KIND_FIND, 0, 32'hFFFF_FFFF);
      issue(KIND_FIND, 0, 32'h8000_0000);
      issue(KIND_REMOVE_VAL, 0, 32'hFFFF_FFFF);
      issue(KIND_REMOVE_AT, 1, 0);
      issue(KIND_REMOVE_AT, 2, 0);
      issue(KIND_POP, 0, 0);
      issue(KIND_POP, 0, 0);
      issue(KIND_POP, 0, 0);
   endtask

   // fill to capacity, hit the full rejections, compact a large match set
   task automatic test_full_list();
      int i;
      for (i = 0; i < DEPTH; i++) issue(KIND_PUSH, 0, (i % 4 == 0) ? 42 : $urandom);
      issue(KIND_PUSH, 0, 1);
      issue(KIND_INSERT, 0, 1);
      issue(KIND_INSERT, 63, 1);
      issue(KIND_GET, 63, 0);
      issue(KIND_FIND, 0, 42);
      issue(KIND_REMOVE_VAL, 0, 42);
      for (i = 0; i < DEPTH / 4; i++) issue(KIND_INSERT, $urandom_range(list_len), 9);
      issue(KIND_REMOVE_AT, 0, 0);
      issue(KIND_INSERT, list_len, 9);
      issue(KIND_REMOVE_VAL, 0, 9);
   endtask

   // random operand: mostly a list entry or a small pool so find and remove value hit often
   function automatic logic [31:0] pick_value();
      logic [31:0] pool [6] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'd3, 32'd123456};
      if (list_len > 0 && $urandom_range(3) == 0)
         return list_mem[$urandom_range(list_len - 1)];
      if ($urandom_range(9) < 5) return pool[$urandom_range(5)];
      return $urandom;
   endfunction

   // random mix that swings the fill level between empty and full
   task automatic test_random_mix(input int n_items);
      req_type r;
      int      roll;
      int      i;
      for (i = 0; i < n_items; i++) begin
         if (list_len >= DEPTH) grow_bias = 1'b0;
         else if (list_len <= 2) grow_bias = 1'b1;
         else if ($urandom_range(99) == 0) grow_bias = ~grow_bias;
         roll = $urandom_range(99);
         if (grow_bias) begin
            if (roll < 32) r.kind = KIND_PUSH;
            else if (roll < 48) r.kind = KIND_INSERT;
            else if (roll < 55) r.kind = KIND_POP;
            else if (roll < 62) r.kind = KIND_REMOVE_AT;
            else if (roll < 68) r.kind = KIND_REMOVE_VAL;
            else if (roll < 82) r.kind = KIND_GET;
            else if (roll < 96) r.kind = KIND_FIND;
            else r.kind = KIND_UNDEFINED;
         end else begin
            if (roll < 8) r.kind = KIND_PUSH;
            else if (roll < 16) r.kind = KIND_INSERT;
            else if (roll < 40) r.kind = KIND_POP;
            else if (roll < 60) r.kind = KIND_REMOVE_AT;
            else if (roll < 70) r.kind = KIND_REMOVE_VAL;
            else if (roll < 83) r.kind = KIND_GET;
            else if (roll < 96) r.kind = KIND_FIND;
            else r.kind = KIND_UNDEFINED;
         end
         // mostly legal indexes, some anywhere in the field
         if ($urandom_range(9) < 2) r.position = 6'($urandom_range(63));
         else if (r.kind == KIND_INSERT) r.position = 6'($urandom_range(list_len));
         else if (list_len > 0) r.position = 6'($urandom_range(list_len - 1));
         else r.position = '0;
         r.operand_value = pick_value();
         send_request(r);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct = 0;
      test_empty_list();
      test_edit_ops();
      wait_drained();

      sender_idle_pct = 21;
      test_full_list();
      wait_drained();

      // idle phases: none, sender idle 87%, none (result side cannot stall), 21%
      sender_idle_pct = 0;
      test_random_mix(230);
      wait_drained();
      sender_idle_pct = 87;
      test_random_mix(230);
      wait_drained();
      sender_idle_pct = 0;
      test_random_mix(230);
      wait_drained();
      sender_idle_pct = 21;
      test_random_mix(230);
      wait_drained();

      if (pending_results.size() != 0) begin
         $error("%0d predicted results never arrived", pending_results.size());
         fail_count++;
      end
      $display("Covered %0d requests over empty, partial and full lists; %0d results checked",
               sent_count, checked_count);
      $display("Status counts ok/empty/full/bad index/not found: %0d/%0d/%0d/%0d/%0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4]);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
